// ===== src/sid_pkg.sv =====
package sid_pkg;

   // Width and reset value of the parallel limit register.
   localparam int unsigned LIMIT_W = 33;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 33'd1;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_ON_BOTH  = 2'd0,
      ST_PARALLEL = 2'd1,
      ST_OFF_SEG  = 2'd2,
      ST_SAT      = 2'd3
   } status_type;

endpackage

// ===== src/sid_req_if.sv =====
interface sid_req_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] ax;
   logic signed [COORD_WIDTH-1:0] ay;
   logic signed [COORD_WIDTH-1:0] bx;
   logic signed [COORD_WIDTH-1:0] by;
   logic signed [COORD_WIDTH-1:0] cx;
   logic signed [COORD_WIDTH-1:0] cy;
   logic signed [COORD_WIDTH-1:0] dx;
   logic signed [COORD_WIDTH-1:0] dy;

   modport source (output valid, ax, ay, bx, by, cx, cy, dx, dy, input ready);
   modport sink (input valid, ax, ay, bx, by, cx, cy, dx, dy, output ready);
endinterface

// ===== src/sid_rsp_if.sv =====
interface sid_rsp_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] cross_x;
   logic signed [COORD_WIDTH-1:0] cross_y;
   sid_pkg::status_type           status;

   modport source (output valid, cross_x, cross_y, status, input ready);
   modport sink (input valid, cross_x, cross_y, status, output ready);
endinterface

// ===== src/segment_intersection_2d.sv =====
// Intersection of two 2D segments A-B and C-D in signed fixed point. One item
// is taken per clock cycle while no result stalls, and each result passes
// through six front stages, the divider with one overflow stage and
// COORD_WIDTH + 2 quotient stages of one bit each, and three final stages. A
// stall on the result side holds the whole pipeline. Lines whose
// determinant magnitude is zero or below csr_wr_data as last written (reset
// value 1) report status 1 with zero coordinates. The crossing point is exact,
// truncated toward zero, and clamped to the coordinate range with status 3;
// status 0 means the point lies on both segments, status 2 that it does not.
module segment_intersection_2d #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [sid_pkg::LIMIT_W-1:0]   csr_wr_data,
   sid_req_if.sink                       req,
   sid_rsp_if.source                     rsp
);

   localparam int CW      = COORD_WIDTH;
   localparam int DW      = CW + 1;          // coordinate difference
   localparam int PW      = 2 * DW;          // 2x2 product
   localparam int DETW    = PW + 1;          // determinant / numerator
   localparam int MW      = PW;              // their magnitudes
   localparam int LW      = MW / 2;          // half of a magnitude
   localparam int TW      = MW + DW;         // dividend
   localparam int QW      = CW + 2;          // quotient bits kept
   localparam int QS      = QW + 2;          // signed sum width
   localparam int DIV_LAT = QW + 1;
   localparam int NSTG    = 6 + DIV_LAT + 3;

   localparam logic signed [QS-1:0] HI_Q = {{(QS-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [QS-1:0] LO_Q = {{(QS-CW+1){1'b1}}, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] HI_C = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] LO_C = {1'b1, {(CW-1){1'b0}}};

   typedef struct packed {
      logic signed [CW-1:0] ax;
      logic signed [CW-1:0] ay;
      logic signed [CW-1:0] bx;
      logic signed [CW-1:0] by;
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
   } coord_type;

   typedef struct packed {
      coord_type pt;
      logic      para;
      logic      neg_x;
      logic      neg_y;
   } side_type;

   // True when p lies inclusively between a and b.
   function automatic logic span_hit(logic signed [CW-1:0] p, logic signed [CW-1:0] a,
                                     logic signed [CW-1:0] b);
      return ((p >= a) && (p <= b)) || ((p >= b) && (p <= a));
   endfunction

   logic [sid_pkg::LIMIT_W-1:0] limit_ff;
   logic [NSTG-1:0]             vld_ff;
   logic                        en;

   // Parallel limit register.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= sid_pkg::LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // The whole pipeline advances unless a finished result waits.
   assign en        = !vld_ff[NSTG-1] || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTG-2:0], req.valid};
      end
   end

   // Stage 1: direction and offset vectors.
   coord_type              s1_pt_ff;
   logic signed [DW-1:0]   s1_ux_ff, s1_uy_ff, s1_vx_ff, s1_vy_ff, s1_wx_ff, s1_wy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_pt_ff <= '{ax: req.ax, ay: req.ay, bx: req.bx, by: req.by,
                        cx: req.cx, cy: req.cy, dx: req.dx, dy: req.dy};
         s1_ux_ff <= DW'(req.bx) - DW'(req.ax);
         s1_uy_ff <= DW'(req.by) - DW'(req.ay);
         s1_vx_ff <= DW'(req.dx) - DW'(req.cx);
         s1_vy_ff <= DW'(req.dy) - DW'(req.cy);
         s1_wx_ff <= DW'(req.cx) - DW'(req.ax);
         s1_wy_ff <= DW'(req.cy) - DW'(req.ay);
      end
   end

   // Stage 2: the four cross products.
   coord_type              s2_pt_ff;
   logic signed [DW-1:0]   s2_ux_ff, s2_uy_ff;
   logic signed [PW-1:0]   s2_p0_ff, s2_p1_ff, s2_p2_ff, s2_p3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_pt_ff <= s1_pt_ff;
         s2_ux_ff <= s1_ux_ff;
         s2_uy_ff <= s1_uy_ff;
         s2_p0_ff <= PW'(s1_ux_ff) * PW'(s1_vy_ff);
         s2_p1_ff <= PW'(s1_uy_ff) * PW'(s1_vx_ff);
         s2_p2_ff <= PW'(s1_wx_ff) * PW'(s1_vy_ff);
         s2_p3_ff <= PW'(s1_wy_ff) * PW'(s1_vx_ff);
      end
   end

   // Stage 3: determinant and numerator.
   coord_type              s3_pt_ff;
   logic signed [DW-1:0]   s3_ux_ff, s3_uy_ff;
   logic signed [DETW-1:0] s3_det_ff, s3_num_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s3_pt_ff  <= s2_pt_ff;
         s3_ux_ff  <= s2_ux_ff;
         s3_uy_ff  <= s2_uy_ff;
         s3_det_ff <= DETW'(s2_p0_ff) - DETW'(s2_p1_ff);
         s3_num_ff <= DETW'(s2_p2_ff) - DETW'(s2_p3_ff);
      end
   end

   // Stage 4: magnitudes, quotient signs and the parallel test.
   logic [DETW-1:0] s4_dabs, s4_nabs;
   logic [DW-1:0]   s4_uxabs, s4_uyabs;
   side_type        s4_side_ff;
   logic [MW-1:0]   s4_dmag_ff, s4_nmag_ff;
   logic [DW-1:0]   s4_uxmag_ff, s4_uymag_ff;

   always_comb begin
      s4_dabs  = s3_det_ff[DETW-1] ? DETW'(-s3_det_ff) : DETW'(s3_det_ff);
      s4_nabs  = s3_num_ff[DETW-1] ? DETW'(-s3_num_ff) : DETW'(s3_num_ff);
      s4_uxabs = s3_ux_ff[DW-1] ? DW'(-s3_ux_ff) : DW'(s3_ux_ff);
      s4_uyabs = s3_uy_ff[DW-1] ? DW'(-s3_uy_ff) : DW'(s3_uy_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_side_ff.pt    <= s3_pt_ff;
         s4_side_ff.para  <= (s4_dabs == '0) || (s4_dabs < DETW'(limit_ff));
         s4_side_ff.neg_x <= s3_det_ff[DETW-1] ^ s3_num_ff[DETW-1] ^ s3_ux_ff[DW-1];
         s4_side_ff.neg_y <= s3_det_ff[DETW-1] ^ s3_num_ff[DETW-1] ^ s3_uy_ff[DW-1];
         s4_dmag_ff       <= s4_dabs[MW-1:0];
         s4_nmag_ff       <= s4_nabs[MW-1:0];
         s4_uxmag_ff      <= s4_uxabs;
         s4_uymag_ff      <= s4_uyabs;
      end
   end

   // Stage 5: numerator times direction, in two halves.
   side_type        s5_side_ff;
   logic [MW-1:0]   s5_dmag_ff;
   logic [2*LW-1:0] s5_xlo_ff, s5_xhi_ff, s5_ylo_ff, s5_yhi_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s5_side_ff <= s4_side_ff;
         s5_dmag_ff <= s4_dmag_ff;
         s5_xlo_ff  <= (2*LW)'(s4_nmag_ff[LW-1:0]) * (2*LW)'(s4_uxmag_ff);
         s5_xhi_ff  <= (2*LW)'(s4_nmag_ff[MW-1:LW]) * (2*LW)'(s4_uxmag_ff);
         s5_ylo_ff  <= (2*LW)'(s4_nmag_ff[LW-1:0]) * (2*LW)'(s4_uymag_ff);
         s5_yhi_ff  <= (2*LW)'(s4_nmag_ff[MW-1:LW]) * (2*LW)'(s4_uymag_ff);
      end
   end

   // Stage 6: partial products summed into the dividends.
   side_type      s6_side_ff;
   logic [MW-1:0] s6_dmag_ff;
   logic [TW-1:0] s6_tx_ff, s6_ty_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s6_side_ff <= s5_side_ff;
         s6_dmag_ff <= s5_dmag_ff;
         s6_tx_ff   <= TW'(s5_xlo_ff) + (TW'(s5_xhi_ff) << LW);
         s6_ty_ff   <= TW'(s5_ylo_ff) + (TW'(s5_yhi_ff) << LW);
      end
   end

   // Quotient magnitudes, with side data delayed alongside.
   logic [QW-1:0] qx, qy;
   logic          ovx, ovy;
   side_type      dly_ff [0:DIV_LAT-1];

   sid_div #(.NUM_W(TW), .DEN_W(MW), .QUO_W(QW)) u_div_x (
      .clock(clock), .en(en), .num_in(s6_tx_ff), .den_in(s6_dmag_ff),
      .quo_out(qx), .ovf_out(ovx)
   );

   sid_div #(.NUM_W(TW), .DEN_W(MW), .QUO_W(QW)) u_div_y (
      .clock(clock), .en(en), .num_in(s6_ty_ff), .den_in(s6_dmag_ff),
      .quo_out(qy), .ovf_out(ovy)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         dly_ff[0] <= s6_side_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   // Final stage 1: signed quotient added to the start point.
   side_type              f1_side_ff;
   logic signed [QS-1:0]  f1_px_ff, f1_py_ff;
   logic                  f1_ovx_ff, f1_ovy_ff;
   logic signed [QS-1:0]  f1_qx, f1_qy;

   always_comb begin
      f1_qx = dly_ff[DIV_LAT-1].neg_x ? -QS'(qx) : QS'(qx);
      f1_qy = dly_ff[DIV_LAT-1].neg_y ? -QS'(qy) : QS'(qy);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_side_ff <= dly_ff[DIV_LAT-1];
         f1_px_ff   <= QS'(dly_ff[DIV_LAT-1].pt.ax) + f1_qx;
         f1_py_ff   <= QS'(dly_ff[DIV_LAT-1].pt.ay) + f1_qy;
         f1_ovx_ff  <= ovx;
         f1_ovy_ff  <= ovy;
      end
   end

   // Final stage 2: clamp to the coordinate range.
   side_type             f2_side_ff;
   logic signed [CW-1:0] f2_rx_ff, f2_ry_ff;
   logic                 f2_sat_ff;
   logic                 f2_hix, f2_lox, f2_hiy, f2_loy;

   always_comb begin
      f2_hix = f1_ovx_ff ? !f1_side_ff.neg_x : (f1_px_ff > HI_Q);
      f2_lox = f1_ovx_ff ?  f1_side_ff.neg_x : (f1_px_ff < LO_Q);
      f2_hiy = f1_ovy_ff ? !f1_side_ff.neg_y : (f1_py_ff > HI_Q);
      f2_loy = f1_ovy_ff ?  f1_side_ff.neg_y : (f1_py_ff < LO_Q);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f2_side_ff <= f1_side_ff;
         f2_rx_ff   <= f2_hix ? HI_C : (f2_lox ? LO_C : f1_px_ff[CW-1:0]);
         f2_ry_ff   <= f2_hiy ? HI_C : (f2_loy ? LO_C : f1_py_ff[CW-1:0]);
         f2_sat_ff  <= f2_hix || f2_lox || f2_hiy || f2_loy;
      end
   end

   // Final stage 3: span test and the result register.
   logic signed [CW-1:0] out_x_ff, out_y_ff;
   sid_pkg::status_type  out_st_ff;
   logic                 f3_hit;

   always_comb begin
      f3_hit = span_hit(f2_rx_ff, f2_side_ff.pt.ax, f2_side_ff.pt.bx) &&
               span_hit(f2_rx_ff, f2_side_ff.pt.cx, f2_side_ff.pt.dx) &&
               span_hit(f2_ry_ff, f2_side_ff.pt.ay, f2_side_ff.pt.by) &&
               span_hit(f2_ry_ff, f2_side_ff.pt.cy, f2_side_ff.pt.dy);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (f2_side_ff.para) begin
            out_x_ff  <= '0;
            out_y_ff  <= '0;
            out_st_ff <= sid_pkg::ST_PARALLEL;
         end else begin
            out_x_ff  <= f2_rx_ff;
            out_y_ff  <= f2_ry_ff;
            if (f2_sat_ff) begin
               out_st_ff <= sid_pkg::ST_SAT;
            end else if (f3_hit) begin
               out_st_ff <= sid_pkg::ST_ON_BOTH;
            end else begin
               out_st_ff <= sid_pkg::ST_OFF_SEG;
            end
         end
      end
   end

   assign rsp.valid   = vld_ff[NSTG-1];
   assign rsp.cross_x = out_x_ff;
   assign rsp.cross_y = out_y_ff;
   assign rsp.status  = out_st_ff;

`ifndef SYNTHESIS
   // A parallel result carries zero coordinates.
   a_para_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.status == sid_pkg::ST_PARALLEL) |-> (rsp.cross_x == '0) &&
      (rsp.cross_y == '0))
      else $error("parallel result with nonzero coordinates");

   // A waiting result blocks new transfers on the input.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("input accepted while result stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid after reset");

   // A saturated coordinate sits at one end of the range.
   a_sat_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.status == sid_pkg::ST_SAT) |-> (rsp.cross_x == HI_C) ||
      (rsp.cross_x == LO_C) || (rsp.cross_y == HI_C) || (rsp.cross_y == LO_C))
      else $error("saturated result not clamped");
`endif

endmodule

// ===== src/sid_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, unsigned operands.
// The first stage flags a quotient that does not fit in QUO_W bits.
module sid_div #(
   parameter int NUM_W = 99,
   parameter int DEN_W = 66,
   parameter int QUO_W = 34
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num_in,
   input  logic [DEN_W-1:0] den_in,
   output logic [QUO_W-1:0] quo_out,
   output logic             ovf_out
);

   localparam int RW = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

   logic [RW-1:0]    rem_ff [0:QUO_W];
   logic [DEN_W-1:0] den_ff [0:QUO_W];
   logic [QUO_W-1:0] quo_ff [0:QUO_W];
   logic             ovf_ff [0:QUO_W];

   // Overflow check: the quotient fits only if num < den * 2^QUO_W.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RW'(num_in);
         den_ff[0] <= den_in;
         quo_ff[0] <= '0;
         ovf_ff[0] <= RW'(num_in) >= (RW'(den_in) << QUO_W);
      end
   end

   // One trial subtraction per stage, most significant quotient bit first.
   for (genvar k = 1; k <= QUO_W; k++) begin : g_step
      logic [RW:0]   trial_in;
      logic [RW-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      always_comb begin
         trial_in = {1'b0, rem_ff[k-1]} - ((RW+1)'(den_ff[k-1]) << (QUO_W - k));
         rem_in   = rem_ff[k-1];
         quo_in   = quo_ff[k-1];
         if (!trial_in[RW]) begin
            rem_in             = trial_in[RW-1:0];
            quo_in[QUO_W - k]  = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= den_ff[k-1];
            quo_ff[k] <= quo_in;
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quo_out = quo_ff[QUO_W];
   assign ovf_out = ovf_ff[QUO_W];

endmodule
